@@ rtl/core/kdoc_pkg.sv @@
package kdoc_pkg;

  // KISS special characters.
  localparam logic [7:0] FEND  = 8'hC0;
  localparam logic [7:0] FESC  = 8'hDB;
  localparam logic [7:0] TFEND = 8'hDC;
  localparam logic [7:0] TFESC = 8'hDD;

  // Saturation limit of the running frame byte count.
  localparam int unsigned MAX_COUNT = 1023;
  localparam int unsigned CNT_W     = $clog2(MAX_COUNT + 1);

  // Field widths.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CALL_W = 48;
  localparam int unsigned SSID_W = 5;
  localparam int unsigned LEN_W  = 10;
  localparam int unsigned CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  localparam logic [LEN_W-1:0] LEN_MAX = 10'd1023;

  // AX.25 source address positions within the frame.
  localparam logic [CNT_W-1:0] POS_CALL_FIRST = CNT_W'(7);
  localparam logic [CNT_W-1:0] POS_CALL_LAST  = CNT_W'(12);
  localparam logic [CNT_W-1:0] POS_SSID       = CNT_W'(13);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_CALLSIGN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_SSID         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME_LENGTH = 2'd2;

  localparam int unsigned CFG_DATA_W = CALL_W;

  // Reset values of the configuration registers.
  localparam logic [CALL_W-1:0] OWN_CALLSIGN_RST = 48'h2020_2020_2020;
  localparam logic [SSID_W-1:0] OWN_SSID_RST     = 5'd16;
  localparam logic [LEN_W-1:0]  MIN_LEN_RST      = 10'd20;

  // One result item.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              frame_done;
    logic [LEN_W-1:0]  frame_length;
    logic              own_source_heard;
  } result_t;

endpackage

@@ rtl/core/kdoc_deframer.sv @@
// Deframing state and per-byte decode. One byte is consumed whenever go is
// high; the matching result, if any, is presented combinationally.
module kdoc_deframer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         go,
  input  logic [kdoc_pkg::BYTE_W-1:0]  rx_byte,
  input  logic [kdoc_pkg::CALL_W-1:0]  own_callsign,
  input  logic [kdoc_pkg::SSID_W-1:0]  own_ssid,
  input  logic [kdoc_pkg::LEN_W-1:0]   min_frame_length,
  output logic                         res_valid,
  output kdoc_pkg::result_t            res
);

  logic                        esc_r,   esc_nxt;
  logic                        await_r, await_nxt;
  logic [kdoc_pkg::CNT_W-1:0]  cnt_r,   cnt_nxt;
  logic                        call_r,  call_nxt;
  logic                        ssid_r,  ssid_nxt;

  logic                        emit;
  logic [kdoc_pkg::BYTE_W-1:0] emit_byte;
  logic [2:0]                  call_idx;
  logic [kdoc_pkg::BYTE_W-1:0] want;
  logic [kdoc_pkg::CMP_W-1:0]  len_ext;

  assign len_ext  = kdoc_pkg::CMP_W'(cnt_r);
  assign call_idx = 3'(kdoc_pkg::POS_CALL_LAST - cnt_r);

  // Expected callsign character; index 5 is the first character.
  always_comb begin
    unique case (call_idx)
      3'd5:    want = own_callsign[47:40];
      3'd4:    want = own_callsign[39:32];
      3'd3:    want = own_callsign[31:24];
      3'd2:    want = own_callsign[23:16];
      3'd1:    want = own_callsign[15:8];
      default: want = own_callsign[7:0];
    endcase
  end

  always_comb begin
    esc_nxt   = esc_r;
    await_nxt = await_r;
    cnt_nxt   = cnt_r;
    call_nxt  = call_r;
    ssid_nxt  = ssid_r;
    emit      = 1'b0;
    emit_byte = rx_byte;
    res_valid = 1'b0;
    res       = '0;

    if (go) begin
      priority if (esc_r) begin
        esc_nxt = 1'b0;
        if (rx_byte == kdoc_pkg::TFEND) begin
          emit      = 1'b1;
          emit_byte = kdoc_pkg::FEND;
        end else if (rx_byte == kdoc_pkg::TFESC) begin
          emit      = 1'b1;
          emit_byte = kdoc_pkg::FESC;
        end
      end else if (rx_byte == kdoc_pkg::FEND) begin
        res_valid            = (len_ext > kdoc_pkg::CMP_W'(min_frame_length));
        res.frame_done       = 1'b1;
        res.own_source_heard = call_r & ssid_r;
        if (len_ext > kdoc_pkg::CMP_W'(kdoc_pkg::LEN_MAX)) begin
          res.frame_length = kdoc_pkg::LEN_MAX;
        end else begin
          res.frame_length = len_ext[kdoc_pkg::LEN_W-1:0];
        end
        await_nxt = 1'b1;
        cnt_nxt   = '0;
        call_nxt  = 1'b1;
        ssid_nxt  = 1'b0;
      end else if (await_r) begin
        await_nxt = 1'b0;
      end else if (rx_byte == kdoc_pkg::FESC) begin
        esc_nxt = 1'b1;
      end else begin
        emit = 1'b1;
      end
    end

    if (emit) begin
      res_valid     = 1'b1;
      res.data_byte = emit_byte;
      if (cnt_r >= kdoc_pkg::POS_CALL_FIRST && cnt_r <= kdoc_pkg::POS_CALL_LAST) begin
        if (emit_byte[7:1] != want[6:0] || want[7]) begin
          call_nxt = 1'b0;
        end
      end else if (cnt_r == kdoc_pkg::POS_SSID) begin
        ssid_nxt = own_ssid[4] || ({1'b0, emit_byte[4:1]} == own_ssid);
      end
      if (cnt_r != kdoc_pkg::CNT_W'(kdoc_pkg::MAX_COUNT)) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r   <= 1'b0;
      await_r <= 1'b1;
      cnt_r   <= '0;
      call_r  <= 1'b1;
      ssid_r  <= 1'b0;
    end else begin
      esc_r   <= esc_nxt;
      await_r <= await_nxt;
      cnt_r   <= cnt_nxt;
      call_r  <= call_nxt;
      ssid_r  <= ssid_nxt;
    end
  end

endmodule

@@ rtl/core/kiss_deframe_own_call_detect_core.sv @@
// KISS receive deframer with own-callsign detection.
//
// Input channel (in_valid / in_ready / in_rx_byte) takes raw bytes from the
// KISS serial link, one item per handshake. Output channel (out_valid /
// out_ready / out_*) delivers either an unescaped frame byte (frame_done = 0)
// or, at a closing FEND of a long enough frame, a frame report carrying the
// length and whether the AX.25 source matches the own callsign and SSID.
// Escape bytes, type bytes and short frames produce no output item.
//
// The configuration port (cfg_we / cfg_index / cfg_wdata) writes own callsign,
// own SSID and minimum frame length; write it only while the block is idle.
//
// Timing: an accepted byte is held in the input register and decoded once the
// output register has room; its result, if any, is loaded into the output
// register at that decode step. One byte per cycle is sustained while the
// receiver does not stall. When the receiver stalls, the output register holds
// its item and the input register fills, after which in_ready drops. Reset
// clears the deframing state (the next byte is a type byte), empties both
// registers and restores the register defaults.
module kiss_deframe_own_call_detect_core (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [kdoc_pkg::BYTE_W-1:0]     in_rx_byte,

  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kdoc_pkg::BYTE_W-1:0]     out_data_byte,
  output logic                            out_frame_done,
  output logic [kdoc_pkg::LEN_W-1:0]      out_frame_length,
  output logic                            out_own_source_heard,

  input  logic                            cfg_we,
  input  logic [kdoc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kdoc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [kdoc_pkg::CALL_W-1:0] own_callsign_r;
  logic [kdoc_pkg::SSID_W-1:0] own_ssid_r;
  logic [kdoc_pkg::LEN_W-1:0]  min_len_r;

  // Input register.
  logic                        in_valid_r;
  logic [kdoc_pkg::BYTE_W-1:0] in_byte_r;

  // Output register.
  logic                        out_valid_r;
  kdoc_pkg::result_t           out_res_r;

  logic                        go;
  logic                        res_valid;
  kdoc_pkg::result_t           res;

  // The buffered byte is decoded once the output register has room for
  // whatever it might produce.
  assign go       = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_callsign_r <= kdoc_pkg::OWN_CALLSIGN_RST;
      own_ssid_r     <= kdoc_pkg::OWN_SSID_RST;
      min_len_r      <= kdoc_pkg::MIN_LEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kdoc_pkg::CFG_OWN_CALLSIGN:
          own_callsign_r <= cfg_wdata[kdoc_pkg::CALL_W-1:0];
        kdoc_pkg::CFG_OWN_SSID:
          own_ssid_r <= cfg_wdata[kdoc_pkg::SSID_W-1:0];
        kdoc_pkg::CFG_MIN_FRAME_LENGTH:
          min_len_r <= cfg_wdata[kdoc_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  kdoc_deframer u_deframer (
    .clk              (clk),
    .rst_n            (rst_n),
    .go               (go),
    .rx_byte          (in_byte_r),
    .own_callsign     (own_callsign_r),
    .own_ssid         (own_ssid_r),
    .min_frame_length (min_len_r),
    .res_valid        (res_valid),
    .res              (res)
  );

  // The output register loads on every decode step and otherwise empties
  // once its item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_data_byte        = out_res_r.data_byte;
  assign out_frame_done       = out_res_r.frame_done;
  assign out_frame_length     = out_res_r.frame_length;
  assign out_own_source_heard = out_res_r.own_source_heard;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import kdoc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  // Two register stages sit between an accepted byte and its result, so the
  // quiet cycles below are enough to be sure nothing is still in flight.
  localparam int DRAIN_CYCLES = 8;
  localparam int SHOW_LIMIT   = 10;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_rx_byte  = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [BYTE_W-1:0]     out_data_byte;
  logic                  out_frame_done;
  logic [LEN_W-1:0]      out_frame_length;
  logic                  out_own_source_heard;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

  kiss_deframe_own_call_detect_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_data_byte        (out_data_byte),
    .out_frame_done       (out_frame_done),
    .out_frame_length     (out_frame_length),
    .out_own_source_heard (out_own_source_heard),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  // Shadow copy of the configuration registers, starting from reset values.
  logic [CALL_W-1:0] own_call = OWN_CALLSIGN_RST;
  logic [SSID_W-1:0] own_ssid = OWN_SSID_RST;
  logic [LEN_W-1:0]  min_len  = MIN_LEN_RST;

  // Shadow copy of the deframing state.
  logic esc_pending = 1'b0;
  logic want_type   = 1'b1;
  int   frame_pos   = 0;
  logic call_ok     = 1'b1;
  logic ssid_ok     = 1'b0;

  // Results that the block still owes us, oldest first.
  result_t pending_results[$];

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int reports_seen = 0;
  int own_reports  = 0;
  int mismatches   = 0;
  int cycle_count  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is cut off here if the block stops moving items.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
               pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // The receiver stalls each cycle with the chance that the current phase sets.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Appends one result to the list of results still owed.
  function automatic void owe_result(input result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // A FEND (or reset) opens a new frame: the next non-FEND byte is the KISS
  // type byte, and the source address compare starts over.
  function automatic void open_frame();
    want_type = 1'b1;
    frame_pos = 0;
    call_ok   = 1'b1;
    ssid_ok   = 1'b0;
  endfunction

  // One unescaped frame byte goes out. Bytes 7 to 12 carry the source callsign
  // shifted left by one; byte 13 carries the SSID in bits 4..1.
  function automatic void pass_frame_byte(input logic [BYTE_W-1:0] c);
    result_t r;
    if (frame_pos >= 7 && frame_pos <= 12) begin
      if ({1'b0, c[7:1]} != own_call[8*(12-frame_pos) +: 8])
        call_ok = 1'b0;
    end else if (frame_pos == 13) begin
      ssid_ok = (own_ssid > 5'd15) || ({1'b0, c[4:1]} == own_ssid);
    end
    if (frame_pos < MAX_COUNT)
      frame_pos++;
    r = '0;
    r.data_byte = c;
    owe_result(r);
  endfunction

  // Works out what one accepted raw byte makes the block produce.
  function automatic void deframe_predict(input logic [BYTE_W-1:0] b);
    result_t r;
    if (esc_pending) begin
      // Only TFEND and TFESC complete an escape; anything else, a FEND too,
      // is dropped along with the FESC.
      esc_pending = 1'b0;
      if (b == TFEND)
        pass_frame_byte(FEND);
      else if (b == TFESC)
        pass_frame_byte(FESC);
    end else if (b == FEND) begin
      if (frame_pos > min_len) begin
        r = '0;
        r.frame_done       = 1'b1;
        r.frame_length     = (frame_pos > LEN_MAX) ? LEN_MAX : LEN_W'(frame_pos);
        r.own_source_heard = call_ok && ssid_ok;
        owe_result(r);
      end
      open_frame();
    end else if (want_type) begin
      // The type byte is taken raw, so even a FESC here is just dropped.
      want_type = 1'b0;
    end else if (b == FESC) begin
      esc_pending = 1'b1;
    end else begin
      pass_frame_byte(b);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got.data_byte        = out_data_byte;
      got.frame_done       = out_frame_done;
      got.frame_length     = out_frame_length;
      got.own_source_heard = out_own_source_heard;
      results_seen++;
      if (got.frame_done) begin
        reports_seen++;
        if (got.own_source_heard)
          own_reports++;
      end
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("%0t: result with nothing owed: byte %02h done %0b len %0d own %0b",
                   $realtime, got.data_byte, got.frame_done, got.frame_length,
                   got.own_source_heard);
      end else begin
        want = pending_results.pop_front();
        if (got.data_byte != want.data_byte || got.frame_done != want.frame_done ||
            got.frame_length != want.frame_length ||
            got.own_source_heard != want.own_source_heard) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("%0t: mismatch, expected byte %02h done %0b len %0d own %0b, %s",
                     $realtime, want.data_byte, want.frame_done, want.frame_length,
                     want.own_source_heard,
                     $sformatf("got byte %02h done %0b len %0d own %0b",
                               got.data_byte, got.frame_done, got.frame_length,
                               got.own_source_heard));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sends one raw byte. Valid is dropped only for an idle gap, and the payload
  // holds until the handshake completes.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct && gap < 30)
      gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    deframe_predict(b);
    items_sent++;
  endtask

  // Holds the sender off until every owed result has come out, then lets the
  // pipeline settle, since bytes that make no result may still be inside.
  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only with the block idle. Bits above the
  // register's width carry random junk that the block must ignore.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CALL_W-1:0] value);
    logic [CFG_DATA_W-1:0] wdata;
    wait_results_done();
    wdata = {16'($urandom), 32'($urandom)};
    case (idx)
      CFG_OWN_CALLSIGN: begin
        wdata    = value;
        own_call = value;
      end
      CFG_OWN_SSID: begin
        wdata[SSID_W-1:0] = value[SSID_W-1:0];
        own_ssid          = value[SSID_W-1:0];
      end
      CFG_MIN_FRAME_LENGTH: begin
        wdata[LEN_W-1:0] = value[LEN_W-1:0];
        min_len          = value[LEN_W-1:0];
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= wdata;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Sends a frame byte, escaped the KISS way when it is FEND or FESC.
  task automatic send_escaped(input logic [BYTE_W-1:0] c);
    if (c == FEND) begin
      send_byte(FESC);
      send_byte(TFEND);
    end else if (c == FESC) begin
      send_byte(FESC);
      send_byte(TFESC);
    end else begin
      send_byte(c);
    end
  endtask

  // Builds a KISS frame holding content_len unescaped bytes: a random
  // destination, a source address that matches the own station or misses it
  // by one character or the SSID, and a payload rich in FEND and FESC.
  task automatic send_frame(input bit hit_own, input int content_len);
    logic [BYTE_W-1:0] body[$];
    logic [BYTE_W-1:0] c;
    int                miss;
    for (int i = 0; i < 7; i++)
      body.insert(body.size(), 8'($urandom));
    for (int i = 0; i < 6; i++)
      body.insert(body.size(), {own_call[8*(5-i) +: 7], 1'($urandom)});
    c = 8'($urandom);
    if (own_ssid <= 5'd15)
      c[4:1] = own_ssid[3:0];
    body.insert(body.size(), c);
    if (!hit_own) begin
      miss = $urandom_range(7, (own_ssid <= 5'd15) ? 13 : 12);
      if (miss == 13)
        body[13][4:1] = body[13][4:1] + 4'd1;
      else
        body[miss] = body[miss] ^ (8'd1 << $urandom_range(1, 7));
    end
    while (body.size() < content_len) begin
      case ($urandom_range(0, 7))
        0:       body.insert(body.size(), FEND);
        1:       body.insert(body.size(), FESC);
        default: body.insert(body.size(), 8'($urandom));
      endcase
    end
    while (body.size() > content_len)
      void'(body.pop_back());

    // A spare leading FEND now and then exercises the repeated FEND case.
    if ($urandom_range(0, 2) == 0)
      send_byte(FEND);
    do c = 8'($urandom); while (c == FEND);
    send_byte(c);
    foreach (body[i])
      send_escaped(body[i]);
    send_byte(FEND);
  endtask

  // Raw link garbage: stray escapes, broken escape pairs and lone FENDs,
  // closed by two FENDs so that framing is back in step afterwards even when
  // a trailing FESC swallows the first of them.
  task automatic send_line_noise();
    int                n;
    logic [BYTE_W-1:0] b;
    n = $urandom_range(2, 12);
    repeat (n) begin
      case ($urandom_range(0, 6))
        0:       b = FEND;
        1:       b = FESC;
        2:       b = TFEND;
        3:       b = TFESC;
        default: b = 8'($urandom);
      endcase
      send_byte(b);
    end
    send_byte(FEND);
    send_byte(FEND);
  endtask

  // Mostly uppercase letters, digits and spaces, with the odd arbitrary byte.
  function automatic logic [CALL_W-1:0] random_callsign();
    string             alphabet;
    logic [CALL_W-1:0] call;
    alphabet = " ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    for (int i = 0; i < 6; i++) begin
      if ($urandom_range(0, 15) == 0)
        call[8*i +: 8] = 8'($urandom);
      else
        call[8*i +: 8] = alphabet[$urandom_range(0, alphabet.len() - 1)];
    end
    return call;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Escapes, type bytes and frame boundaries, with every non-empty frame reported.
  task automatic test_escapes_and_framing();
    write_cfg(CFG_MIN_FRAME_LENGTH, 48'd0);
    // The first byte after reset is treated as a type byte.
    send_byte(8'h55);
    // Zero bytes are ordinary data.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(FESC);
    send_byte(TFEND);
    send_byte(FESC);
    send_byte(TFESC);
    // A FESC followed by anything else swallows both bytes, a FEND as well.
    send_byte(FESC);
    send_byte(8'h41);
    send_byte(FESC);
    send_byte(FEND);
    // This FEND closes a four-byte frame, which is too short to carry a
    // source address and so cannot be our own.
    send_byte(FEND);
    // Back-to-back FENDs close empty frames and report nothing.
    send_byte(FEND);
    send_byte(FEND);
    // A raw FESC in the type slot is simply dropped.
    send_byte(FESC);
    send_byte(8'h10);
    send_byte(FEND);
  endtask

  // Source address matching against several own stations and SSID settings.
  task automatic test_own_callsign();
    write_cfg(CFG_OWN_CALLSIGN, 48'h5445_5354_3720);
    write_cfg(CFG_OWN_SSID, 48'd5);
    write_cfg(CFG_MIN_FRAME_LENGTH, 48'd14);
    send_frame(1'b1, 20);
    send_frame(1'b0, 20);
    send_frame(1'b0, 20);
    // Length must exceed the minimum: 14 bytes stay silent, 15 are reported.
    send_frame(1'b1, 14);
    send_frame(1'b1, 15);
    // A frame that stops inside the callsign is never our own.
    send_frame(1'b1, 10);
    // SSID 16 is a wildcard.
    write_cfg(CFG_OWN_SSID, 48'd16);
    send_frame(1'b1, 20);
    send_frame(1'b0, 20);
    write_cfg(CFG_OWN_SSID, 48'd0);
    write_cfg(CFG_OWN_CALLSIGN, 48'h0);
    send_frame(1'b1, 18);
    send_frame(1'b0, 18);
    // With the top bit set in every character, nothing can ever match.
    write_cfg(CFG_OWN_SSID, 48'd15);
    write_cfg(CFG_OWN_CALLSIGN, 48'hFFFF_FFFF_FFFF);
    send_frame(1'b1, 18);
    write_cfg(CFG_OWN_CALLSIGN, OWN_CALLSIGN_RST);
    send_frame(1'b1, 18);
    write_cfg(CFG_MIN_FRAME_LENGTH, 48'd1023);
    send_frame(1'b1, 30);
  endtask

  // Frames long enough to saturate the byte count, at both top minimums.
  task automatic test_length_saturation();
    write_cfg(CFG_MIN_FRAME_LENGTH, 48'd1022);
    send_frame(1'b1, 1030);
    write_cfg(CFG_MIN_FRAME_LENGTH, 48'd1023);
    send_frame(1'b1, 1026);
  endtask

  // Random mix of well-formed frames, short frames and link noise under one
  // idling pattern and one configuration.
  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items,
                                     input int ssid, input int min_length);
    int first;
    int pick;
    write_cfg(CFG_OWN_CALLSIGN, random_callsign());
    write_cfg(CFG_OWN_SSID, 48'(ssid));
    write_cfg(CFG_MIN_FRAME_LENGTH, 48'(min_length));
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    first = items_sent;
    while (items_sent - first < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        send_frame(pick < 40, $urandom_range(14, 40));
      else if (pick < 80)
        send_frame(1'($urandom_range(0, 1)), $urandom_range(0, 13));
      else if (pick < 96)
        send_line_noise();
      else
        wait_results_done();
    end
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
  endtask

  initial begin
    // Reset is held low from the start and then released for good.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_escapes_and_framing();
    test_own_callsign();
    test_length_saturation();
    test_random_traffic(0, 0, 100, $urandom_range(0, 15), 0);
    test_random_traffic(51, 0, 100, 16, 20);
    test_random_traffic(0, 51, 100, 15, $urandom_range(1, 30));
    test_random_traffic(9, 9, 100, 0, 13);

    wait_results_done();
    $display("Sent %0d raw bytes; checked %0d results, %0d frame reports (%0d own).",
             items_sent, results_seen, reports_seen, own_reports);
    $display("Covered escapes, type bytes, short and saturated frames, four idling phases.");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
